// File: hdl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg: shared types and codes for the indexed min-heap
// Command and status codes, the slot entry, the datapath micro-operations
// and the status word that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int ID_COUNT_DEF = 1024;

    localparam int ID_WIDTH    = 10;
    localparam int KEY_WIDTH   = 32;
    localparam int CMD_WIDTH   = 2;
    localparam int STAT_WIDTH  = 3;
    localparam int COUNT_WIDTH = 11;

    localparam logic [CMD_WIDTH-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_DECREASE = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_EXTRACT  = 2'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_QUERY    = 2'd3;

    localparam logic [STAT_WIDTH-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_WIDTH-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_WIDTH-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_WIDTH-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STAT_WIDTH-1:0] ST_PRESENT = 3'd4;

    typedef struct packed {
        logic [ID_WIDTH-1:0]  id;
        logic [KEY_WIDTH-1:0] key;
    } slot_entry_t;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CLEAR   = 4'd1,
        OP_ACCEPT  = 4'd2,
        OP_LOOKUP  = 4'd3,
        OP_KEY     = 4'd4,
        OP_EXTLAST = 4'd5,
        OP_UP      = 4'd6,
        OP_UPCMP   = 4'd7,
        OP_DN      = 4'd8,
        OP_DNL     = 4'd9,
        OP_DNR     = 4'd10,
        OP_LOAD    = 4'd11
    } dp_op_t;

    typedef struct packed {
        logic                 clr_done;
        logic [CMD_WIDTH-1:0] cmd;
        logic                 id_ok;
        logic                 member;
        logic                 full;
        logic                 empty;
        logic                 at_root;
        logic                 no_left;
        logic                 has_right;
        logic                 move;
    } dp_status_t;

endpackage

// File: hdl/imh_dp.sv
// ----------------------------------------------------------------------------
// imh_dp: heap datapath
// Slot memory, position map, working registers for the sifted entry and the
// result registers. Carries out one micro-operation per cycle.
// ----------------------------------------------------------------------------
module imh_dp import imh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_COUNT = ID_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_op_t                 op,
    input  logic [CMD_WIDTH-1:0]   cmd,
    input  logic [ID_WIDTH-1:0]    node_id,
    input  logic [KEY_WIDTH-1:0]   key,
    output dp_status_t             st,
    output logic [STAT_WIDTH-1:0]  status,
    output logic [ID_WIDTH-1:0]    out_id,
    output logic [KEY_WIDTH-1:0]   out_key,
    output logic                   is_member,
    output logic [COUNT_WIDTH-1:0] entry_count
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IW     = CNT_W + 1;
    localparam int IDX_W  = $clog2(ID_COUNT);
    localparam logic [CNT_W-1:0] ABSENT = CNT_W'(CAPACITY);

    slot_entry_t slot_mem [CAPACITY];
    logic [CNT_W-1:0] pos_mem [ID_COUNT];

    slot_entry_t      rd_q;
    logic [CNT_W-1:0] pos_q;

    logic [CMD_WIDTH-1:0] cmd_reg;
    logic [ID_WIDTH-1:0]  id_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 id_ok_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SLOT_W-1:0]    i_reg;
    slot_entry_t          cur_reg;
    slot_entry_t          lft_reg;
    logic                 lft_lt_reg;
    logic [IDX_W-1:0]     clr_reg;

    logic [STAT_WIDTH-1:0] res_status_reg;
    logic [ID_WIDTH-1:0]   res_id_reg;
    logic [KEY_WIDTH-1:0]  res_key_reg;
    logic                  res_mem_reg;

    logic [STAT_WIDTH-1:0]  out_status_reg;
    logic [ID_WIDTH-1:0]    out_id_reg;
    logic [KEY_WIDTH-1:0]   out_key_reg;
    logic                   out_mem_reg;
    logic [COUNT_WIDTH-1:0] out_cnt_reg;

    logic [IW-1:0]     left_idx;
    logic [IW-1:0]     right_idx;
    logic [IW-1:0]     cnt_x;
    logic [SLOT_W-1:0] parent;
    logic              member;
    logic              full;
    logic              empty;
    logic              at_root;
    logic              no_left;
    logic              has_right;
    logic              left_lt;
    logic              right_lt;
    logic              up_lt;
    logic [KEY_WIDTH-1:0] best_key;
    logic              move;
    logic              ins_ok;

    logic              slot_we;
    logic [SLOT_W-1:0] slot_wa;
    slot_entry_t       slot_wd;
    logic [SLOT_W-1:0] slot_ra;
    logic              pos_we;
    logic [IDX_W-1:0]  pos_wa;
    logic [CNT_W-1:0]  pos_wd;

    assign left_idx  = IW'({i_reg, 1'b1});
    assign right_idx = left_idx + IW'(1);
    assign cnt_x     = IW'(cnt_reg);
    assign parent    = (i_reg - SLOT_W'(1)) >> 1;
    assign member    = pos_q < cnt_reg;
    assign full      = cnt_reg == ABSENT;
    assign empty     = cnt_reg == '0;
    assign at_root   = i_reg == '0;
    assign no_left   = left_idx >= cnt_x;
    assign has_right = right_idx < cnt_x;
    assign left_lt   = rd_q.key < cur_reg.key;
    assign best_key  = lft_lt_reg ? lft_reg.key : cur_reg.key;
    assign right_lt  = rd_q.key < best_key;
    assign up_lt     = cur_reg.key < rd_q.key;
    assign ins_ok    = id_ok_reg && !member && !full;

    always_comb
    begin
        case (op)
            OP_UPCMP: move = up_lt;
            OP_DNL:   move = left_lt;
            OP_DNR:   move = right_lt || lft_lt_reg;
            default:  move = 1'b0;
        endcase
    end

    always_comb
    begin
        st.clr_done  = clr_reg == IDX_W'(ID_COUNT - 1);
        st.cmd       = cmd_reg;
        st.id_ok     = id_ok_reg;
        st.member    = member;
        st.full      = full;
        st.empty     = empty;
        st.at_root   = at_root;
        st.no_left   = no_left;
        st.has_right = has_right;
        st.move      = move;
    end

    always_comb
    begin
        case (op)
            OP_LOOKUP: slot_ra = (cmd_reg == CMD_EXTRACT) ? SLOT_W'(cnt_reg - CNT_W'(1))
                                                          : SLOT_W'(pos_q);
            OP_UP:     slot_ra = parent;
            OP_DN:     slot_ra = SLOT_W'(left_idx);
            OP_DNL:    slot_ra = SLOT_W'(right_idx);
            default:   slot_ra = '0;
        endcase
    end

    // Hole method: the sifted entry stays in cur_reg and lands once at the end
    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = i_reg;
        slot_wd = cur_reg;
        pos_we  = 1'b0;
        pos_wa  = IDX_W'(cur_reg.id);
        pos_wd  = CNT_W'(i_reg);
        case (op)
            OP_CLEAR:
            begin
                pos_we = 1'b1;
                pos_wa = clr_reg;
                pos_wd = ABSENT;
            end
            OP_LOOKUP:
            begin
                if (cmd_reg == CMD_EXTRACT && !empty)
                begin
                    pos_we = 1'b1;
                    pos_wa = IDX_W'(rd_q.id);
                    pos_wd = ABSENT;
                end
            end
            OP_UP:
            begin
                slot_we = at_root;
                pos_we  = at_root;
            end
            OP_UPCMP:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if (up_lt)
                begin
                    slot_wd = rd_q;
                    pos_wa  = IDX_W'(rd_q.id);
                end
            end
            OP_DN:
            begin
                slot_we = no_left;
                pos_we  = no_left;
            end
            OP_DNL:
            begin
                slot_we = !has_right;
                pos_we  = !has_right;
                if (left_lt)
                begin
                    slot_wd = rd_q;
                    pos_wa  = IDX_W'(rd_q.id);
                end
            end
            OP_DNR:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if (right_lt)
                begin
                    slot_wd = rd_q;
                    pos_wa  = IDX_W'(rd_q.id);
                end
                else if (lft_lt_reg)
                begin
                    slot_wd = lft_reg;
                    pos_wa  = IDX_W'(lft_reg.id);
                end
            end
            default:
            begin
                slot_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        rd_q <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (op == OP_ACCEPT)
        begin
            pos_q <= pos_mem[IDX_W'(node_id)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (op == OP_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (op == OP_LOOKUP)
            begin
                if (cmd_reg == CMD_EXTRACT && !empty)
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                else if (cmd_reg == CMD_INSERT && ins_ok)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_ACCEPT:
            begin
                cmd_reg        <= cmd;
                id_reg         <= node_id;
                key_reg        <= key;
                id_ok_reg      <= 32'(node_id) < ID_COUNT;
                res_status_reg <= ST_OK;
                res_id_reg     <= node_id;
                res_key_reg    <= '0;
                res_mem_reg    <= 1'b0;
            end
            OP_LOOKUP:
            begin
                cur_reg.id  <= id_reg;
                cur_reg.key <= key_reg;
                if (cmd_reg == CMD_EXTRACT)
                begin
                    if (empty)
                    begin
                        res_status_reg <= ST_EMPTY;
                        res_id_reg     <= '0;
                    end
                    else
                    begin
                        res_id_reg  <= rd_q.id;
                        res_key_reg <= rd_q.key;
                    end
                end
                else if (!id_ok_reg)
                begin
                    res_status_reg <= ST_ABSENT;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    i_reg <= SLOT_W'(cnt_reg);
                    if (member)
                    begin
                        res_status_reg <= ST_PRESENT;
                    end
                    else
                    begin
                        res_key_reg <= key_reg;
                        if (full)
                        begin
                            res_status_reg <= ST_FULL;
                        end
                    end
                end
                else if (cmd_reg == CMD_DECREASE)
                begin
                    i_reg <= SLOT_W'(pos_q);
                    if (member)
                    begin
                        res_key_reg <= key_reg;
                    end
                    else
                    begin
                        res_status_reg <= ST_ABSENT;
                    end
                end
                else
                begin
                    res_mem_reg <= member;
                end
            end
            OP_KEY:
            begin
                res_key_reg <= rd_q.key;
            end
            OP_EXTLAST:
            begin
                cur_reg <= rd_q;
                i_reg   <= '0;
            end
            OP_UPCMP:
            begin
                if (up_lt)
                begin
                    i_reg <= parent;
                end
            end
            OP_DNL:
            begin
                lft_reg    <= rd_q;
                lft_lt_reg <= left_lt;
                if (!has_right && left_lt)
                begin
                    i_reg <= SLOT_W'(left_idx);
                end
            end
            OP_DNR:
            begin
                if (right_lt)
                begin
                    i_reg <= SLOT_W'(right_idx);
                end
                else if (lft_lt_reg)
                begin
                    i_reg <= SLOT_W'(left_idx);
                end
            end
            OP_LOAD:
            begin
                out_status_reg <= res_status_reg;
                out_id_reg     <= res_id_reg;
                out_key_reg    <= res_key_reg;
                out_mem_reg    <= res_mem_reg;
                out_cnt_reg    <= COUNT_WIDTH'(cnt_reg);
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    assign status      = out_status_reg;
    assign out_id      = out_id_reg;
    assign out_key     = out_key_reg;
    assign is_member   = out_mem_reg;
    assign entry_count = out_cnt_reg;

endmodule

// File: hdl/imh_ctrl.sv
// ----------------------------------------------------------------------------
// imh_ctrl: heap controller
// Sequences the clearing pass, the lookup, sift-up and sift-down steps, and
// runs both handshakes.
// ----------------------------------------------------------------------------
module imh_ctrl import imh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t st,
    output dp_op_t     op
);

    typedef enum logic [10:0] {
        S_CLR     = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_LOOKUP  = 11'b000_0000_0100,
        S_KEY     = 11'b000_0000_1000,
        S_EXTLAST = 11'b000_0001_0000,
        S_UP      = 11'b000_0010_0000,
        S_UPCMP   = 11'b000_0100_0000,
        S_DN      = 11'b000_1000_0000,
        S_DNL     = 11'b001_0000_0000,
        S_DNR     = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign load      = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_CLR:
            begin
                op = OP_CLEAR;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_ACCEPT;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                op         = OP_LOOKUP;
                state_next = S_DONE;
                if (st.cmd == CMD_EXTRACT)
                begin
                    if (!st.empty)
                    begin
                        state_next = S_EXTLAST;
                    end
                end
                else if (st.id_ok)
                begin
                    case (st.cmd)
                        CMD_INSERT:
                        begin
                            if (st.member)
                            begin
                                state_next = S_KEY;
                            end
                            else if (!st.full)
                            begin
                                state_next = S_UP;
                            end
                        end
                        CMD_DECREASE:
                        begin
                            if (st.member)
                            begin
                                state_next = S_UP;
                            end
                        end
                        default:
                        begin
                            if (st.member)
                            begin
                                state_next = S_KEY;
                            end
                        end
                    endcase
                end
            end
            S_KEY:
            begin
                op         = OP_KEY;
                state_next = S_DONE;
            end
            S_EXTLAST:
            begin
                // last entry was the root: nothing left to sift
                op         = OP_EXTLAST;
                state_next = st.empty ? S_DONE : S_DN;
            end
            S_UP:
            begin
                op         = OP_UP;
                state_next = st.at_root ? S_DONE : S_UPCMP;
            end
            S_UPCMP:
            begin
                op         = OP_UPCMP;
                state_next = st.move ? S_UP : S_DONE;
            end
            S_DN:
            begin
                op         = OP_DN;
                state_next = st.no_left ? S_DONE : S_DNL;
            end
            S_DNL:
            begin
                op = OP_DNL;
                if (st.has_right)
                begin
                    state_next = S_DNR;
                end
                else
                begin
                    state_next = st.move ? S_DN : S_DONE;
                end
            end
            S_DNR:
            begin
                op         = OP_DNR;
                state_next = st.move ? S_DN : S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    op         = OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LOOKUP))
        else $error("accepted transfer did not start a lookup");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_sift_up_loops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPCMP && st.move) |=> (state_reg == S_UP))
        else $error("sift-up swap did not continue");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR && !st.clr_done) |=> !in_ready)
        else $error("input taken during clearing pass");

endmodule

// File: hdl/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap: indexed binary min-heap with decrease-key
// Insert, decrease-key, extract-minimum and membership query on (id, key)
// pairs, with a position map from id to heap slot.
//
//   Channel  Handshake            Fields
//   in       in_valid / in_ready  cmd, node_id, key
//   out      out_valid/out_ready  status, out_id, out_key, is_member,
//                                 entry_count
//
// One item at a time: a new item is accepted only after the result of the
// last one is loaded. Absent ids, full heap and non-member query end at
// the lookup; member query and duplicate insert also read the stored key.
// Insert and decrease-key sift up, reading and comparing the parent for
// each level climbed. Extract moves the last entry to the root and sifts
// it down, reading the left and then the right child through the single
// read port of the slot memory. After reset a clearing pass marks every
// id absent; in_ready stays low meanwhile. A result held by out_ready low
// stalls only the completion of the following item.
// ----------------------------------------------------------------------------
module indexed_min_heap import imh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_COUNT = ID_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_WIDTH-1:0]   cmd,
    input  logic [ID_WIDTH-1:0]    node_id,
    input  logic [KEY_WIDTH-1:0]   key,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STAT_WIDTH-1:0]  status,
    output logic [ID_WIDTH-1:0]    out_id,
    output logic [KEY_WIDTH-1:0]   out_key,
    output logic                   is_member,
    output logic [COUNT_WIDTH-1:0] entry_count
);

    dp_op_t     op;
    dp_status_t st;

    imh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .op        (op)
    );

    imh_dp #(
        .CAPACITY (CAPACITY),
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .cmd         (cmd),
        .node_id     (node_id),
        .key         (key),
        .st          (st),
        .status      (status),
        .out_id      (out_id),
        .out_key     (out_key),
        .is_member   (is_member),
        .entry_count (entry_count)
    );

endmodule
